// File: hw/rtl/feba_pkg.sv
package feba_pkg;

  localparam int BLK_W  = 10;
  localparam int LEN_W  = 11;
  localparam int VOL_W  = 11;
  localparam int FUNC_W = 2;
  localparam int STAT_W = 2;

  localparam logic [FUNC_W-1:0] FN_ALLOC   = 2'd0;
  localparam logic [FUNC_W-1:0] FN_RELEASE = 2'd1;
  localparam logic [FUNC_W-1:0] FN_FORMAT  = 2'd2;
  localparam logic [FUNC_W-1:0] FN_NOP     = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

  localparam logic [VOL_W-1:0] VOL_RESET = 11'd1024;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [BLK_W-1:0]  block_number;
  } in_word_t;

  typedef struct packed {
    logic [BLK_W-1:0]  granted_block;
    logic [STAT_W-1:0] status;
  } out_word_t;

  typedef struct packed {
    logic [LEN_W-1:0] length;
    logic [BLK_W-1:0] link;
  } extent_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

endpackage

// File: hw/rtl/feba_ram.sv
module feba_ram #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/free_extent_block_allocator.sv
// Block allocator keeping free space as a linked list of extents in one
// synchronous RAM (length and next pointer per extent start), with the list
// head in a register. For every command (allocate, release, format) start
// is taken when busy is low; busy is high in the following cycle while the
// RAM is written (allocate may shorten the head extent, release and format
// write a new one), and the result word is shown on out_word with out_strobe
// high for exactly one cycle after that. The receiver cannot stall the
// block; a new command may be issued in the same cycle the previous result
// is strobed. Write cfg_wdata (volume size) only while the block is idle.
module free_extent_block_allocator #(
  parameter int MAX_BLOCKS = 1024
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  feba_pkg::in_word_t       in_word,
  output logic                     out_strobe,
  output feba_pkg::out_word_t      out_word,
  input  logic                     cfg_we,
  input  logic [feba_pkg::VOL_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(MAX_BLOCKS);
  localparam int EW = $bits(feba_pkg::extent_t);

  feba_pkg::state_t               state_r, state_nxt;
  feba_pkg::in_word_t             op_r;
  logic [feba_pkg::BLK_W-1:0]     head_r, head_nxt;
  logic [feba_pkg::VOL_W-1:0]     vol_r;
  feba_pkg::out_word_t            out_word_r, out_word_nxt;
  logic                           out_strobe_r, out_strobe_nxt;

  logic                           mem_we;
  logic [AW-1:0]                  mem_waddr;
  feba_pkg::extent_t              mem_wdata;
  logic [EW-1:0]                  mem_rdata;
  feba_pkg::extent_t              ext;
  logic [feba_pkg::LEN_W-1:0]     len_dec;
  logic [feba_pkg::VOL_W-1:0]     eff_size;
  logic                           accept;

  assign accept   = start && !busy;
  assign ext      = feba_pkg::extent_t'(mem_rdata);
  assign len_dec  = ext.length - feba_pkg::LEN_W'(1);
  assign eff_size = (32'(vol_r) < MAX_BLOCKS) ? vol_r : feba_pkg::VOL_W'(MAX_BLOCKS);

  feba_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_BLOCKS)
  ) u_extent_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (EW'(mem_wdata)),
    .raddr (AW'(head_r)),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      feba_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = feba_pkg::S_EXEC;
        end
      end
      feba_pkg::S_EXEC: begin
        state_nxt = feba_pkg::S_IDLE;
      end
      default: begin
        state_nxt = feba_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    busy                       = (state_r == feba_pkg::S_EXEC);
    mem_we                     = 1'b0;
    mem_waddr                  = AW'(head_r);
    mem_wdata                  = ext;
    head_nxt                   = head_r;
    out_strobe_nxt             = (state_r == feba_pkg::S_EXEC);
    out_word_nxt.granted_block = '0;
    out_word_nxt.status        = feba_pkg::ST_OK;
    if (state_r == feba_pkg::S_EXEC) begin
      case (op_r.func)
        feba_pkg::FN_ALLOC: begin
          if (head_r == '0 || 32'(head_r) >= MAX_BLOCKS) begin
            out_word_nxt.status = feba_pkg::ST_EMPTY;
          end else if (ext.length <= feba_pkg::LEN_W'(1)) begin
            out_word_nxt.granted_block = head_r;
            head_nxt                   = ext.link;
          end else begin
            mem_we                     = 1'b1;
            mem_wdata.length           = len_dec;
            mem_wdata.link             = ext.link;
            out_word_nxt.granted_block = head_r + len_dec[feba_pkg::BLK_W-1:0];
          end
        end
        feba_pkg::FN_RELEASE: begin
          if (op_r.block_number == '0 ||
              feba_pkg::VOL_W'(op_r.block_number) >= eff_size) begin
            out_word_nxt.status = feba_pkg::ST_RANGE;
          end else begin
            mem_we           = 1'b1;
            mem_waddr        = AW'(op_r.block_number);
            mem_wdata.length = feba_pkg::LEN_W'(1);
            mem_wdata.link   = head_r;
            head_nxt         = op_r.block_number;
          end
        end
        feba_pkg::FN_FORMAT: begin
          if (eff_size < feba_pkg::VOL_W'(2)) begin
            head_nxt = '0;
          end else begin
            mem_we           = 1'b1;
            mem_waddr        = AW'(1);
            mem_wdata.length = feba_pkg::LEN_W'(eff_size - feba_pkg::VOL_W'(1));
            mem_wdata.link   = '0;
            head_nxt         = feba_pkg::BLK_W'(1);
          end
        end
        default: begin
          head_nxt = head_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= feba_pkg::S_IDLE;
      head_r       <= '0;
      vol_r        <= feba_pkg::VOL_RESET;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) begin
        vol_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= in_word;
    end
    out_word_r <= out_word_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == feba_pkg::S_EXEC))
    else $error("accepted command did not enter execute");

  a_strobe_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == feba_pkg::S_EXEC) |=> out_strobe)
    else $error("result strobe missing after execute");

  a_head_only_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == feba_pkg::S_IDLE) |=> $stable(head_r))
    else $error("free list head changed outside execute");

  a_range_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_word.status == feba_pkg::ST_RANGE) |-> (out_word.granted_block == '0))
    else $error("rejected release reported a granted block");

endmodule

// File: sim/tb_free_extent_block_allocator.sv
module tb_free_extent_block_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_BLOCKS = 1024;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_PER_PHASE = 220;

  class alloc_scoreboard;
    logic [feba_pkg::VOL_W-1:0] vol_size;
    logic [feba_pkg::BLK_W-1:0] head;
    logic [feba_pkg::LEN_W-1:0] ext_len [MAX_BLOCKS];
    logic [feba_pkg::BLK_W-1:0] ext_next [MAX_BLOCKS];
    feba_pkg::out_word_t expected_q[$];
    logic [feba_pkg::BLK_W-1:0] granted_q[$];
    int mismatches;

    function new();
      vol_size = feba_pkg::VOL_RESET;
      head = '0;
      mismatches = 0;
    endfunction

    function int eff_size();
      return (int'(vol_size) < MAX_BLOCKS) ? int'(vol_size) : MAX_BLOCKS;
    endfunction

    function void note_command(feba_pkg::in_word_t w);
      feba_pkg::out_word_t r;
      logic [feba_pkg::BLK_W-1:0] h;
      int eff;
      r.granted_block = '0;
      r.status = feba_pkg::ST_OK;
      eff = eff_size();
      case (w.func)
        feba_pkg::FN_ALLOC: begin
          if (head == '0) begin
            r.status = feba_pkg::ST_EMPTY;
          end else begin
            h = head;
            if (ext_len[h] <= 1) begin
              r.granted_block = h;
              head = ext_next[h];
            end else begin
              ext_len[h] = ext_len[h] - 1'b1;
              r.granted_block = h + ext_len[h][feba_pkg::BLK_W-1:0];
            end
            granted_q.push_back(r.granted_block);
            if (granted_q.size() > 64) void'(granted_q.pop_front());
          end
        end
        feba_pkg::FN_RELEASE: begin
          if (w.block_number == '0 || int'(w.block_number) >= eff) begin
            r.status = feba_pkg::ST_RANGE;
          end else begin
            ext_len[w.block_number] = feba_pkg::LEN_W'(1);
            ext_next[w.block_number] = head;
            head = w.block_number;
          end
        end
        feba_pkg::FN_FORMAT: begin
          granted_q.delete();
          if (eff < 2) begin
            head = '0;
          end else begin
            ext_len[1] = feba_pkg::LEN_W'(eff - 1);
            ext_next[1] = '0;
            head = feba_pkg::BLK_W'(1);
          end
        end
        default: ;
      endcase
      expected_q.push_back(r);
    endfunction

    function void check_result(feba_pkg::out_word_t got);
      feba_pkg::out_word_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: granted %0d status %0d",
                   got.granted_block, got.status);
        return;
      end
      want = expected_q.pop_front();
      if (got.granted_block !== want.granted_block || got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: granted exp %0d got %0d, status exp %0d got %0d",
                   want.granted_block, got.granted_block, want.status, got.status);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  feba_pkg::in_word_t in_word;
  logic out_strobe;
  feba_pkg::out_word_t out_word;
  logic cfg_we;
  logic [feba_pkg::VOL_W-1:0] cfg_wdata;

  alloc_scoreboard sb;
  bit no_idle;

  free_extent_block_allocator #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_word(in_word),
    .out_strobe(out_strobe),
    .out_word(out_word),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    sb = new();
  end

  always @(posedge clk) begin
    if (rst_n && start && !busy) sb.note_command(in_word);
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) sb.check_result(out_word);
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb_free_extent_block_allocator: FAIL");
    $finish;
  end

  task automatic send_cmd(logic [feba_pkg::FUNC_W-1:0] f, logic [feba_pkg::BLK_W-1:0] b);
    feba_pkg::in_word_t w;
    int gap;
    w.func = f;
    w.block_number = b;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      start <= 1'b0;
      in_word.func <= feba_pkg::FUNC_W'($urandom);
      in_word.block_number <= feba_pkg::BLK_W'($urandom);
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
  endtask

  task automatic write_volume(logic [feba_pkg::VOL_W-1:0] v);
    start <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    sb.vol_size = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_directed();
    send_cmd(feba_pkg::FN_ALLOC, 10'd0);
    send_cmd(feba_pkg::FN_RELEASE, 10'd0);
    send_cmd(feba_pkg::FN_NOP, 10'd1023);
    send_cmd(feba_pkg::FN_RELEASE, 10'd1023);
    send_cmd(feba_pkg::FN_ALLOC, 10'd1023);
    send_cmd(feba_pkg::FN_ALLOC, 10'd0);
    send_cmd(feba_pkg::FN_FORMAT, 10'd1023);
    send_cmd(feba_pkg::FN_ALLOC, 10'd0);
    send_cmd(feba_pkg::FN_ALLOC, 10'd0);
    // double free links the list into a loop
    send_cmd(feba_pkg::FN_RELEASE, 10'd1022);
    send_cmd(feba_pkg::FN_RELEASE, 10'd1022);
    send_cmd(feba_pkg::FN_ALLOC, 10'd0);
    send_cmd(feba_pkg::FN_ALLOC, 10'd0);
    send_cmd(feba_pkg::FN_FORMAT, 10'd0);
    // shrink the volume under an existing list
    write_volume(11'd10);
    send_cmd(feba_pkg::FN_ALLOC, 10'd0);
    send_cmd(feba_pkg::FN_RELEASE, 10'd500);
    send_cmd(feba_pkg::FN_RELEASE, 10'd9);
    send_cmd(feba_pkg::FN_RELEASE, 10'd10);
    write_volume(11'd2);
    send_cmd(feba_pkg::FN_FORMAT, 10'd0);
    send_cmd(feba_pkg::FN_ALLOC, 10'd0);
    send_cmd(feba_pkg::FN_ALLOC, 10'd0);
    send_cmd(feba_pkg::FN_RELEASE, 10'd1);
    send_cmd(feba_pkg::FN_RELEASE, 10'd2);
    write_volume(11'd0);
    send_cmd(feba_pkg::FN_FORMAT, 10'd0);
    send_cmd(feba_pkg::FN_ALLOC, 10'd0);
    write_volume(11'd1);
    send_cmd(feba_pkg::FN_FORMAT, 10'd0);
    send_cmd(feba_pkg::FN_RELEASE, 10'd1);
    write_volume(11'd2047);
    send_cmd(feba_pkg::FN_FORMAT, 10'd0);
    send_cmd(feba_pkg::FN_RELEASE, 10'd1023);
    send_cmd(feba_pkg::FN_ALLOC, 10'h2aa);
  endtask

  task automatic run_random(int n, bit do_format);
    int pick;
    int sel;
    int idx;
    int eff;
    logic [feba_pkg::FUNC_W-1:0] f;
    logic [feba_pkg::BLK_W-1:0] b;
    if (do_format) send_cmd(feba_pkg::FN_FORMAT, feba_pkg::BLK_W'($urandom));
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      b = feba_pkg::BLK_W'($urandom);
      eff = sb.eff_size();
      if (pick < 52) begin
        f = feba_pkg::FN_ALLOC;
      end else if (pick < 95) begin
        f = feba_pkg::FN_RELEASE;
        sel = $urandom_range(0, 9);
        if (sel < 6 && sb.granted_q.size() > 0) begin
          idx = $urandom_range(0, sb.granted_q.size() - 1);
          b = sb.granted_q[idx];
          sb.granted_q.delete(idx);
        end else if (sel < 9 && eff >= 2) begin
          b = feba_pkg::BLK_W'($urandom_range(1, eff - 1));
        end
      end else if (pick < 98) begin
        f = feba_pkg::FN_FORMAT;
      end else begin
        f = feba_pkg::FN_NOP;
      end
      send_cmd(f, b);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_word <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    no_idle = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();

    write_volume(11'd1024);
    run_random(RANDOM_PER_PHASE, 1'b1);
    write_volume(11'd2);
    run_random(RANDOM_PER_PHASE, 1'b1);
    write_volume(11'd3);
    run_random(RANDOM_PER_PHASE, 1'b1);
    write_volume(11'd17);
    run_random(RANDOM_PER_PHASE, 1'b1);
    write_volume(feba_pkg::VOL_W'($urandom_range(2, 1024)));
    run_random(RANDOM_PER_PHASE, 1'b1);
    // size changed without a new format
    write_volume(feba_pkg::VOL_W'($urandom_range(2, 64)));
    run_random(RANDOM_PER_PHASE, 1'b0);
    write_volume(11'd2047);
    run_random(RANDOM_PER_PHASE, 1'b1);
    write_volume(feba_pkg::VOL_W'($urandom_range(0, 1)));
    run_random(RANDOM_PER_PHASE / 2, 1'b1);
    write_volume(feba_pkg::VOL_W'($urandom_range(1025, 2047)));
    run_random(RANDOM_PER_PHASE / 2, 1'b0);

    start <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("tb_free_extent_block_allocator: PASS");
    end else begin
      $display("tb_free_extent_block_allocator: FAIL");
    end
    $finish;
  end

endmodule
